@@ rtl/lpps_pkg.sv @@
// ----------------------------------------------------------------------------
// lpps_pkg
// Shared widths, sensor gain table, register indexes and arithmetic limits
// for the line position and steering block.
// ----------------------------------------------------------------------------
package lpps_pkg;

    localparam int SENSOR_COUNT = 5;
    localparam int SAMPLE_W     = 12;
    localparam int GAIN_W       = 13;
    localparam int ROUTE_W      = 8;
    localparam int BYTE_W       = 8;
    localparam int POS_OUT_W    = 15;
    localparam int CFG_DATA_W   = 60;
    localparam int CFG_INDEX_W  = 3;

    // Calibrated sample: gain times signed difference plus the shifted floor.
    localparam int CAL_W  = GAIN_W + SAMPLE_W + 2;
    localparam int SUM_W  = CAL_W + 3;
    localparam int WSUM_W = CAL_W + 7;

    localparam int POS_LIMIT = 34;
    localparam int BYTE_BIAS = 100;
    localparam int RPM_MAX   = 255;
    localparam int RPM_SHIFT = 20;

    // Per-sensor gains in Q1.12, left to right.
    localparam logic [GAIN_W-1:0] SENSOR_GAIN [SENSOR_COUNT] = '{
        13'd4096, 13'd4084, 13'd4076, 13'd4084, 13'd4063
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_THRESHOLD    = 3'd0,
        CFG_CALIBRATED_FLOOR  = 3'd1,
        CFG_SENSOR_OFFSETS    = 3'd2,
        CFG_PROPORTIONAL_GAIN = 3'd3,
        CFG_DERIVATIVE_RATE   = 3'd4,
        CFG_FORWARD_SPEED     = 3'd5,
        CFG_WHEEL_BASE        = 3'd6,
        CFG_WHEEL_RPM_FACTOR  = 3'd7
    } lpps_cfg_index_t;

endpackage

@@ rtl/lpps_lane.sv @@
// ----------------------------------------------------------------------------
// lpps_lane
// One sensor lane: line detection and offset, gain and floor calibration.
// ----------------------------------------------------------------------------
module lpps_lane
    import lpps_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [SAMPLE_W-1:0]     sample,
    input  logic [SAMPLE_W-1:0]     offset,
    input  logic [SAMPLE_W-1:0]     threshold,
    input  logic [SAMPLE_W-1:0]     cal_floor,
    input  logic [GAIN_W-1:0]       gain,
    output logic signed [CAL_W-1:0] cal,
    output logic                    on_line
);

    logic signed [SAMPLE_W:0]  diff;
    logic signed [CAL_W-1:0]   prod;
    logic signed [CAL_W-1:0]   floor_q12;

    assign diff      = $signed({1'b0, sample}) - $signed({1'b0, offset});
    assign prod      = $signed({1'b0, gain}) * diff;
    assign floor_q12 = $signed({{(CAL_W - SAMPLE_W - 12){1'b0}}, cal_floor, 12'd0});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cal     <= prod + floor_q12;
            on_line <= (sample > threshold);
        end
    end

endmodule

@@ rtl/lpps_merge.sv @@
// ----------------------------------------------------------------------------
// lpps_merge
// Combines the lane results into the sum and the weighted centroid sum.
// ----------------------------------------------------------------------------
module lpps_merge
    import lpps_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [CAL_W-1:0]  cal [SENSOR_COUNT],
    output logic signed [SUM_W-1:0]  sum,
    output logic signed [WSUM_W-1:0] weighted
);

    logic signed [CAL_W:0]    outer_diff;
    logic signed [CAL_W:0]    inner_diff;
    logic signed [WSUM_W-1:0] outer_ext;
    logic signed [WSUM_W-1:0] inner_ext;
    logic signed [SUM_W-1:0]  sum_c;

    // Weights are -34, -17, 0, 17, 34, so the outer and inner pairs fold.
    assign outer_diff = (CAL_W + 1)'(cal[4]) - (CAL_W + 1)'(cal[0]);
    assign inner_diff = (CAL_W + 1)'(cal[3]) - (CAL_W + 1)'(cal[1]);
    assign outer_ext  = WSUM_W'(outer_diff);
    assign inner_ext  = WSUM_W'(inner_diff);

    always_comb
    begin
        sum_c = '0;
        for (int k = 0; k < SENSOR_COUNT; k++)
        begin
            sum_c = sum_c + SUM_W'(cal[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum      <= sum_c;
            weighted <= (outer_ext <<< 5) + (outer_ext <<< 1)
                      + (inner_ext <<< 4) + inner_ext;
        end
    end

endmodule

@@ rtl/lpps_div.sv @@
// ----------------------------------------------------------------------------
// lpps_div
// Restoring divider, one quotient bit per cycle, for a quotient that is
// known to stay below 2^QUO_W.
// ----------------------------------------------------------------------------
module lpps_div
    import lpps_pkg::*;
#(
    parameter  int FRAC_BITS = 8,
    localparam int QUO_W     = FRAC_BITS + 6,
    localparam int NUM_W     = WSUM_W - 1 + FRAC_BITS,
    localparam int DEN_W     = SUM_W - 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    localparam int REM_W = DEN_W + 1;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [REM_W-1:0] rem_reg;
    logic [QUO_W-1:0] low_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [REM_W-1:0] shifted;
    logic [REM_W:0]   trial;

    assign shifted = {rem_reg[REM_W-2:0], low_reg[QUO_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // The high part of the numerator is below the divisor whenever the
    // quotient is used, so only QUO_W steps are needed.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= REM_W'(num >> QUO_W);
            low_reg <= num[QUO_W-1:0];
        end
        else if (busy_reg)
        begin
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            if (!trial[REM_W])
            begin
                rem_reg <= trial[REM_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/line_position_pd_steering_top.sv @@
// ----------------------------------------------------------------------------
// line_position_pd_steering_top
// Weighted-centroid line position from five reflectance lanes, PD steering
// and differential-drive wheel commands with the transmit frame bytes.
//
//   Channel  Signals                               Beat taken when
//   input    in_valid, in_stall, sample_*, route   in_valid && !in_stall
//   output   out_valid, out_stall, result fields   out_valid && !out_stall
//   config   cfg_write, cfg_index, cfg_data        cfg_write
//
// Each item passes through the lane, merge, saturation, divide, PD, turn,
// mix, speed and RPM states before its result is shown; the restoring
// divider, one quotient bit per cycle, takes most of that time. A new beat is
// taken once the previous result has moved into the output register, so a
// stall on the output holds at most one result while the next item is taken in.
// Reset clears the control state, restores the register defaults and sets
// the previous position to zero.
// ----------------------------------------------------------------------------
module line_position_pd_steering_top
    import lpps_pkg::*;
#(
    parameter int POSITION_FRACTION_BITS = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [SAMPLE_W-1:0]         sample_0,
    input  logic [SAMPLE_W-1:0]         sample_1,
    input  logic [SAMPLE_W-1:0]         sample_2,
    input  logic [SAMPLE_W-1:0]         sample_3,
    input  logic [SAMPLE_W-1:0]         sample_4,
    input  logic [ROUTE_W-1:0]          route_code,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [BYTE_W-1:0]           left_wheel_rpm,
    output logic [BYTE_W-1:0]           right_wheel_rpm,
    output logic [BYTE_W-1:0]           position_byte,
    output logic [BYTE_W-1:0]           route_byte,
    output logic [SENSOR_COUNT-1:0]     line_bits,
    output logic signed [POS_OUT_W-1:0] position_fixed,
    output logic                        sum_invalid,
    input  logic                        cfg_write,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int F         = POSITION_FRACTION_BITS;
    localparam int QUO_W     = F + 6;
    localparam int NUM_W     = WSUM_W - 1 + F;
    localparam int CMP_W     = SUM_W + F + 6;
    localparam int POS_W     = F + 7;
    localparam int LIMIT     = POS_LIMIT * (1 << F);
    localparam int PP_W      = POS_W + 17;
    localparam int PD_W      = POS_W + 18;
    localparam int W_W       = POS_W + 19;
    localparam int WB_W      = W_W + 14;
    localparam int SPD_W     = WB_W + 1;
    localparam int V_LSB     = F + 13;
    localparam int V_W       = SPD_W - 1 - V_LSB;
    localparam int RPROD_W   = V_W + 16;
    localparam int INT_W     = POS_W - F;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_LANE  = 11'b000_0000_0010,
        S_MERGE = 11'b000_0000_0100,
        S_SAT   = 11'b000_0000_1000,
        S_DIV   = 11'b000_0001_0000,
        S_PD    = 11'b000_0010_0000,
        S_TURN  = 11'b000_0100_0000,
        S_MIX   = 11'b000_1000_0000,
        S_SPEED = 11'b001_0000_0000,
        S_RPM   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } lpps_state_t;

    lpps_state_t state_reg, state_next;

    // Configuration registers.
    logic [SAMPLE_W-1:0]   line_threshold_reg;
    logic [SAMPLE_W-1:0]   calibrated_floor_reg;
    logic [CFG_DATA_W-1:0] sensor_offsets_reg;
    logic [15:0]           proportional_gain_reg;
    logic [15:0]           derivative_rate_reg;
    logic [10:0]           forward_speed_reg;
    logic [12:0]           wheel_base_reg;
    logic [15:0]           wheel_rpm_factor_reg;

    logic [SAMPLE_W-1:0]     sample_reg [SENSOR_COUNT];
    logic [ROUTE_W-1:0]      route_reg;
    logic signed [CAL_W-1:0] cal [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] on_line;
    logic signed [SUM_W-1:0] sum;
    logic signed [WSUM_W-1:0] weighted;

    logic                    sat_reg;
    logic                    neg_reg;
    logic                    invalid_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic signed [POS_W-1:0] prev_pos_reg;
    logic signed [PP_W-1:0]  prod_p_reg;
    logic signed [PD_W-1:0]  prod_d_reg;
    logic signed [W_W-1:0]   turn_reg;
    logic signed [WB_W-1:0]  wb_reg;
    logic [V_W-1:0]          v_left_reg;
    logic [V_W-1:0]          v_right_reg;
    logic [BYTE_W-1:0]       rpm_left_reg;
    logic [BYTE_W-1:0]       rpm_right_reg;
    logic                    out_valid_reg;

    logic                    accept;
    logic                    out_load;
    logic [WSUM_W-1:0]       w_abs_full;
    logic [NUM_W-1:0]        num_c;
    logic [SUM_W-2:0]        den_c;
    logic [CMP_W-1:0]        lim_sum_c;
    logic                    div_done;
    logic [QUO_W-1:0]        quotient;
    logic signed [POS_W-1:0] mag_c;
    logic signed [POS_W-1:0] pos_c;
    logic signed [POS_W:0]   pos_diff_c;
    logic signed [SPD_W-1:0] base_c;
    logic signed [SPD_W-1:0] wb_ext_c;
    logic signed [SPD_W-1:0] speed_left_c;
    logic signed [SPD_W-1:0] speed_right_c;
    logic [RPROD_W-1:0]      rprod_left_c;
    logic [RPROD_W-1:0]      rprod_right_c;
    logic [POS_W-1:0]        pos_abs_c;
    logic [INT_W-1:0]        pos_int_c;
    logic [SAMPLE_W-1:0]     samples_in [SENSOR_COUNT];

    assign samples_in = '{sample_0, sample_1, sample_2, sample_3, sample_4};
    assign accept     = in_valid && (state_reg == S_IDLE);
    assign in_stall   = (state_reg != S_IDLE);
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_threshold_reg    <= 12'd2900;
            calibrated_floor_reg  <= 12'd160;
            sensor_offsets_reg    <= 60'd36602057243320480;
            proportional_gain_reg <= 16'd1638;
            derivative_rate_reg   <= 16'd9830;
            forward_speed_reg     <= 11'd300;
            wheel_base_reg        <= 13'd2984;
            wheel_rpm_factor_reg  <= 16'd18691;
        end
        else if (cfg_write)
        begin
            unique case (lpps_cfg_index_t'(cfg_index))
                CFG_LINE_THRESHOLD:    line_threshold_reg    <= cfg_data[SAMPLE_W-1:0];
                CFG_CALIBRATED_FLOOR:  calibrated_floor_reg  <= cfg_data[SAMPLE_W-1:0];
                CFG_SENSOR_OFFSETS:    sensor_offsets_reg    <= cfg_data;
                CFG_PROPORTIONAL_GAIN: proportional_gain_reg <= cfg_data[15:0];
                CFG_DERIVATIVE_RATE:   derivative_rate_reg   <= cfg_data[15:0];
                CFG_FORWARD_SPEED:     forward_speed_reg     <= cfg_data[10:0];
                CFG_WHEEL_BASE:        wheel_base_reg        <= cfg_data[12:0];
                CFG_WHEEL_RPM_FACTOR:  wheel_rpm_factor_reg  <= cfg_data[15:0];
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_LANE;
            S_LANE:  state_next = S_MERGE;
            S_MERGE: state_next = S_SAT;
            S_SAT:   state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_PD;
            S_PD:    state_next = S_TURN;
            S_TURN:  state_next = S_MIX;
            S_MIX:   state_next = S_SPEED;
            S_SPEED: state_next = S_RPM;
            S_RPM:   state_next = S_DONE;
            S_DONE:  if (out_load) state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= samples_in;
            route_reg  <= route_code;
        end
    end

    // ---------------- lanes and merge ----------------
    for (genvar k = 0; k < SENSOR_COUNT; k++)
    begin : g_lane
        lpps_lane u_lane (
            .clk       (clk),
            .en        (state_reg == S_LANE),
            .sample    (sample_reg[k]),
            .offset    (sensor_offsets_reg[SAMPLE_W*k +: SAMPLE_W]),
            .threshold (line_threshold_reg),
            .cal_floor (calibrated_floor_reg),
            .gain      (SENSOR_GAIN[k]),
            .cal       (cal[k]),
            .on_line   (on_line[k])
        );
    end

    lpps_merge u_merge (
        .clk      (clk),
        .en       (state_reg == S_MERGE),
        .cal      (cal),
        .sum      (sum),
        .weighted (weighted)
    );

    // ---------------- saturation check and division ----------------
    assign w_abs_full = weighted[WSUM_W-1] ? (WSUM_W'(0) - weighted) : weighted;
    assign num_c      = {w_abs_full[WSUM_W-2:0], {F{1'b0}}};
    assign den_c      = sum[SUM_W-2:0];
    assign lim_sum_c  = CMP_W'(den_c) * CMP_W'(LIMIT);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SAT)
        begin
            sat_reg     <= (CMP_W'(num_c) >= lim_sum_c);
            neg_reg     <= weighted[WSUM_W-1];
            invalid_reg <= sum[SUM_W-1] || (sum == SUM_W'(0));
        end
    end

    lpps_div #(
        .FRAC_BITS (F)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SAT),
        .num      (num_c),
        .den      (den_c),
        .done     (div_done),
        .quotient (quotient)
    );

    assign mag_c = sat_reg ? POS_W'(LIMIT) : $signed({1'b0, quotient});
    assign pos_c = invalid_reg ? POS_W'(0) : (neg_reg ? -mag_c : mag_c);

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DIV) && div_done)
        begin
            pos_reg <= pos_c;
        end
    end

    // ---------------- PD steering ----------------
    assign pos_diff_c = (POS_W + 1)'(pos_reg) - (POS_W + 1)'(prev_pos_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg <= '0;
        end
        else if (state_reg == S_PD)
        begin
            prev_pos_reg <= pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PD)
        begin
            prod_p_reg <= $signed({1'b0, proportional_gain_reg}) * pos_reg;
            prod_d_reg <= $signed({1'b0, derivative_rate_reg}) * pos_diff_c;
        end
        if (state_reg == S_TURN)
        begin
            turn_reg <= W_W'(prod_p_reg) + W_W'(prod_d_reg);
        end
        if (state_reg == S_MIX)
        begin
            wb_reg <= turn_reg * $signed({1'b0, wheel_base_reg});
        end
    end

    // ---------------- wheel mixing ----------------
    assign base_c = $signed({{(SPD_W - 11 - F - 17){1'b0}}, forward_speed_reg,
                             {(F + 17){1'b0}}});
    assign wb_ext_c      = SPD_W'(wb_reg);
    assign speed_left_c  = base_c - wb_ext_c;
    assign speed_right_c = base_c + wb_ext_c;

    // The truncated speed never reaches 2^30, so only the sign needs care.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SPEED)
        begin
            v_left_reg  <= (speed_left_c > 0)  ? speed_left_c[SPD_W-2:V_LSB]  : '0;
            v_right_reg <= (speed_right_c > 0) ? speed_right_c[SPD_W-2:V_LSB] : '0;
        end
    end

    assign rprod_left_c  = RPROD_W'(v_left_reg) * RPROD_W'(wheel_rpm_factor_reg);
    assign rprod_right_c = RPROD_W'(v_right_reg) * RPROD_W'(wheel_rpm_factor_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RPM)
        begin
            rpm_left_reg  <= ((rprod_left_c >> RPM_SHIFT) > RPROD_W'(RPM_MAX))
                           ? BYTE_W'(RPM_MAX) : rprod_left_c[RPM_SHIFT +: BYTE_W];
            rpm_right_reg <= ((rprod_right_c >> RPM_SHIFT) > RPROD_W'(RPM_MAX))
                           ? BYTE_W'(RPM_MAX) : rprod_right_c[RPM_SHIFT +: BYTE_W];
        end
    end

    // ---------------- frame and output register ----------------
    assign pos_abs_c = pos_reg[POS_W-1] ? (POS_W'(0) - pos_reg) : pos_reg;
    assign pos_int_c = pos_abs_c[POS_W-1:F];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_wheel_rpm  <= rpm_left_reg;
            right_wheel_rpm <= rpm_right_reg;
            position_byte   <= pos_reg[POS_W-1] ? BYTE_W'(pos_int_c)
                             : BYTE_W'(pos_int_c) + BYTE_W'(BYTE_BIAS);
            route_byte      <= route_reg;
            line_bits       <= on_line;
            position_fixed  <= POS_OUT_W'(pos_reg);
            sum_invalid     <= invalid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/lpps_checker.sv @@
// ----------------------------------------------------------------------------
// lpps_checker
// Port-level checks on the line position and steering block, bound to the
// top level.
// ----------------------------------------------------------------------------
module lpps_checker
    import lpps_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [BYTE_W-1:0]           left_wheel_rpm,
    input logic [BYTE_W-1:0]           right_wheel_rpm,
    input logic [BYTE_W-1:0]           position_byte,
    input logic signed [POS_OUT_W-1:0] position_fixed,
    input logic                        sum_invalid
);

    // A held result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // A held result keeps its wheel commands.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(left_wheel_rpm) && $stable(right_wheel_rpm))
        else $error("wheel commands changed while stalled");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second beat taken while an item is in progress");

    // An invalid sum reports the centre position in both forms.
    a_invalid_centre: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sum_invalid |-> (position_fixed == '0) &&
                                     (position_byte == BYTE_W'(BYTE_BIAS)))
        else $error("invalid sum without centre position");

endmodule

bind line_position_pd_steering_top lpps_checker u_lpps_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line position and PD steering block. Sensor
// beats go in through a queue-fed driver, and each accepted beat is run
// through an in-bench model of the centroid, PD and wheel mixing path.
// A monitor compares every result beat, field by field, with the oldest
// prediction. The run covers directed edge cases and random register
// settings, with random gaps on both channels outside the last three phases.
// ----------------------------------------------------------------------------
module tb_top;
    import lpps_pkg::*;

    localparam int     FRAC          = 8;
    localparam longint POS_ONE       = 1 << FRAC;
    localparam longint POS_SAT       = 34 * POS_ONE;
    localparam int     STUCK_LIMIT   = 2000;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     PHASES        = 9;
    localparam int     PHASE_BEATS   = 205;
    localparam logic [CFG_DATA_W-1:0] DEFAULT_OFFSETS = 60'd36602057243320480;

    typedef struct packed {
        logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0] sample;
        logic [ROUTE_W-1:0]                    route;
    } sensor_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0]           left_rpm;
        logic [BYTE_W-1:0]           right_rpm;
        logic [BYTE_W-1:0]           pos_byte;
        logic [BYTE_W-1:0]           route;
        logic [SENSOR_COUNT-1:0]     bits;
        logic signed [POS_OUT_W-1:0] pos;
        logic                        invalid;
    } steering_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   out_stall = 1'b1;
    logic                   cfg_write = 1'b0;
    lpps_cfg_index_t        cfg_index = CFG_LINE_THRESHOLD;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    sensor_beat_t           in_beat   = '0;

    logic                        in_stall;
    logic                        out_valid;
    logic [BYTE_W-1:0]           left_wheel_rpm;
    logic [BYTE_W-1:0]           right_wheel_rpm;
    logic [BYTE_W-1:0]           position_byte;
    logic [BYTE_W-1:0]           route_byte;
    logic [SENSOR_COUNT-1:0]     line_bits;
    logic signed [POS_OUT_W-1:0] position_fixed;
    logic                        sum_invalid;

    // Bench copy of the register file and of the stored position.
    logic [SAMPLE_W-1:0]   thr_reg        = 12'd2900;
    logic [SAMPLE_W-1:0]   floor_reg      = 12'd160;
    logic [CFG_DATA_W-1:0] offsets_reg    = DEFAULT_OFFSETS;
    logic [15:0]           kp_reg         = 16'd1638;
    logic [15:0]           kd_reg         = 16'd9830;
    logic [10:0]           speed_reg      = 11'd300;
    logic [12:0]           base_reg       = 13'd2984;
    logic [15:0]           rpm_factor_reg = 16'd18691;
    longint                last_position  = 0;

    sensor_beat_t     pending_beats[$];
    steering_result_t expected_steering[$];
    steering_result_t got, want;

    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int beats_accepted   = 0;
    int results_seen     = 0;
    int settings_applied = 1;
    int invalid_seen     = 0;
    int saturated_seen   = 0;
    int mismatches       = 0;
    int stuck_cycles     = 0;

    line_position_pd_steering_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample_0        (in_beat.sample[0]),
        .sample_1        (in_beat.sample[1]),
        .sample_2        (in_beat.sample[2]),
        .sample_3        (in_beat.sample[3]),
        .sample_4        (in_beat.sample[4]),
        .route_code      (in_beat.route),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .left_wheel_rpm  (left_wheel_rpm),
        .right_wheel_rpm (right_wheel_rpm),
        .position_byte   (position_byte),
        .route_byte      (route_byte),
        .line_bits       (line_bits),
        .position_fixed  (position_fixed),
        .sum_invalid     (sum_invalid),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [BYTE_W-1:0] rpm_of(longint speed);
        longint unsigned q;
        longint unsigned r;
        if (speed <= 0)
            return '0;
        q = speed >> (FRAC + 13);
        if (q > (64'd1 << 30))
            q = 64'd1 << 30;
        r = (q * rpm_factor_reg) >> 20;
        if (r > 255)
            r = 255;
        return r[BYTE_W-1:0];
    endfunction

    function automatic steering_result_t predict_steering(sensor_beat_t b);
        steering_result_t r;
        longint lane_gain, cal, total, moment, pos, turn, twist, cruise, mag;
        logic [SAMPLE_W-1:0] off;
        int k;
        r = '0;
        total = 0;
        moment = 0;
        for (k = 0; k < SENSOR_COUNT; k++) begin
            case (k)
                0:       lane_gain = 4096;
                1, 3:    lane_gain = 4084;
                2:       lane_gain = 4076;
                default: lane_gain = 4063;
            endcase
            off = offsets_reg[k*SAMPLE_W +: SAMPLE_W];
            if (b.sample[k] > thr_reg)
                r.bits[k] = 1'b1;
            cal = longint'(floor_reg) * 4096
                + lane_gain * (longint'(b.sample[k]) - longint'(off));
            total += cal;
            moment += longint'((k - 2) * 17) * cal;
        end
        if (total <= 0) begin
            r.invalid = 1'b1;
            pos = 0;
            invalid_seen++;
        end
        else begin
            pos = (moment * POS_ONE) / total;
            if (pos > POS_SAT || pos < -POS_SAT)
                saturated_seen++;
            if (pos > POS_SAT)
                pos = POS_SAT;
            else if (pos < -POS_SAT)
                pos = -POS_SAT;
        end
        turn = longint'(kp_reg) * pos + longint'(kd_reg) * (pos - last_position);
        last_position = pos;
        twist = turn * longint'(base_reg);
        cruise = longint'(speed_reg) <<< (FRAC + 17);
        r.left_rpm = rpm_of(cruise - twist);
        r.right_rpm = rpm_of(cruise + twist);
        mag = (pos < 0 ? -pos : pos) >>> FRAC;
        if (pos >= 0)
            mag = mag + 100;
        r.pos_byte = mag[BYTE_W-1:0];
        r.route = b.route;
        r.pos = pos[POS_OUT_W-1:0];
        return r;
    endfunction

    task automatic report_fault(string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("tb_top: mismatch %0d at result %0d: %s", mismatches, results_seen, msg);
    endtask

    task automatic write_reg(lpps_cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_LINE_THRESHOLD:    thr_reg        = value[11:0];
            CFG_CALIBRATED_FLOOR:  floor_reg      = value[11:0];
            CFG_SENSOR_OFFSETS:    offsets_reg    = value;
            CFG_PROPORTIONAL_GAIN: kp_reg         = value[15:0];
            CFG_DERIVATIVE_RATE:   kd_reg         = value[15:0];
            CFG_FORWARD_SPEED:     speed_reg      = value[10:0];
            CFG_WHEEL_BASE:        base_reg       = value[12:0];
            default:               rpm_factor_reg = value[15:0];
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_setting(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] flr,
                                 logic [CFG_DATA_W-1:0] offs, logic [CFG_DATA_W-1:0] kp,
                                 logic [CFG_DATA_W-1:0] kd, logic [CFG_DATA_W-1:0] fs,
                                 logic [CFG_DATA_W-1:0] wb, logic [CFG_DATA_W-1:0] rf);
        write_reg(CFG_LINE_THRESHOLD, thr);
        write_reg(CFG_CALIBRATED_FLOOR, flr);
        write_reg(CFG_SENSOR_OFFSETS, offs);
        write_reg(CFG_PROPORTIONAL_GAIN, kp);
        write_reg(CFG_DERIVATIVE_RATE, kd);
        write_reg(CFG_FORWARD_SPEED, fs);
        write_reg(CFG_WHEEL_BASE, wb);
        write_reg(CFG_WHEEL_RPM_FACTOR, rf);
        settings_applied++;
    endtask

    task automatic push_beat(int s0, int s1, int s2, int s3, int s4, int route);
        sensor_beat_t b;
        b.sample[0] = s0[SAMPLE_W-1:0];
        b.sample[1] = s1[SAMPLE_W-1:0];
        b.sample[2] = s2[SAMPLE_W-1:0];
        b.sample[3] = s3[SAMPLE_W-1:0];
        b.sample[4] = s4[SAMPLE_W-1:0];
        b.route = route[ROUTE_W-1:0];
        pending_beats.push_back(b);
    endtask

    task automatic queue_random_beats(int count);
        sensor_beat_t b;
        int n, k, kind, centre, peak, v;
        for (n = 0; n < count; n++) begin
            kind = $urandom_range(9);
            centre = $urandom_range(SENSOR_COUNT - 1);
            peak = $urandom_range(4095, 1800);
            for (k = 0; k < SENSOR_COUNT; k++) begin
                case (kind)
                    // A dark line under one sensor with partial neighbours on either side.
                    0, 1, 2, 3: begin
                        if (k == centre)
                            v = peak;
                        else if (k == centre - 1 || k == centre + 1)
                            v = $urandom_range(peak);
                        else
                            v = $urandom_range(700);
                    end
                    4, 5:    v = $urandom_range(4095);
                    6:       v = $urandom_range(255);
                    7:       v = int'(thr_reg) + int'($urandom_range(4)) - 2;
                    8:       v = $urandom_range(1) ? 4095 : 0;
                    // Close to the dark offsets, so the sum stays near the floor term alone.
                    default: v = int'(offsets_reg[k*SAMPLE_W +: SAMPLE_W])
                                 + int'($urandom_range(6)) - 3;
                endcase
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
                b.sample[k] = v[SAMPLE_W-1:0];
            end
            b.route = $urandom_range(255);
            pending_beats.push_back(b);
        end
    endtask

    // The sender holds off here until every outstanding result has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_steering.size() != 0);
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_steering.push_back(predict_steering(in_beat));
                beats_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_beat  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                results_seen++;
                got = {left_wheel_rpm, right_wheel_rpm, position_byte, route_byte,
                       line_bits, position_fixed, sum_invalid};
                if (expected_steering.size() == 0) begin
                    report_fault("result beat with nothing expected");
                end
                else begin
                    want = expected_steering.pop_front();
                    if (got.left_rpm !== want.left_rpm)
                        report_fault($sformatf("left_wheel_rpm %0d, expected %0d",
                                               got.left_rpm, want.left_rpm));
                    if (got.right_rpm !== want.right_rpm)
                        report_fault($sformatf("right_wheel_rpm %0d, expected %0d",
                                               got.right_rpm, want.right_rpm));
                    if (got.pos_byte !== want.pos_byte)
                        report_fault($sformatf("position_byte %0d, expected %0d",
                                               got.pos_byte, want.pos_byte));
                    if (got.route !== want.route)
                        report_fault($sformatf("route_byte %0d, expected %0d",
                                               got.route, want.route));
                    if (got.bits !== want.bits)
                        report_fault($sformatf("line_bits %b, expected %b",
                                               got.bits, want.bits));
                    if (got.pos !== want.pos)
                        report_fault($sformatf("position_fixed %0d, expected %0d",
                                               got.pos, want.pos));
                    if (got.invalid !== want.invalid)
                        report_fault($sformatf("sum_invalid %b, expected %b",
                                               got.invalid, want.invalid));
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Counts cycles in which work is outstanding but no beat moves.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write
                || (pending_beats.size() == 0 && !in_valid
                    && expected_steering.size() == 0)) begin
                stuck_cycles <= 0;
            end
            else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("tb_top: no beat moved for %0d cycles", STUCK_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end
            else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    initial begin
        int ph, k;
        logic [CFG_DATA_W-1:0] offs;
        send_idle_pct = 19;
        recv_idle_pct = 76;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: line extremes, threshold edges and route patterns.
        push_beat(0, 0, 0, 0, 0, 8'h00);
        push_beat(4095, 4095, 4095, 4095, 4095, 8'hFF);
        push_beat(4095, 0, 0, 0, 0, 8'h55);
        push_beat(0, 0, 0, 0, 4095, 8'hAA);
        push_beat(0, 0, 4095, 0, 0, 8'h01);
        push_beat(2900, 2900, 2900, 2900, 2900, 8'h80);
        push_beat(2901, 2901, 2901, 2901, 2901, 8'h7F);
        push_beat(4095, 0, 4095, 0, 4095, 8'h0F);
        push_beat(0, 4095, 0, 4095, 0, 8'hF0);
        push_beat(0, 4095, 4095, 0, 0, 8'h3C);
        push_beat(0, 0, 1000, 4095, 0, 8'hC3);
        push_beat(4095, 4095, 0, 0, 0, 8'h99);
        wait_drained();

        // With no floor the sum can reach zero or go negative.
        write_reg(CFG_CALIBRATED_FLOOR, 60'd0);
        push_beat(0, 0, 0, 0, 0, 8'h11);
        push_beat(160, 150, 140, 150, 130, 8'h22);
        push_beat(159, 150, 140, 150, 132, 8'h33);
        push_beat(162, 150, 140, 150, 129, 8'h44);
        push_beat(160, 150, 140, 150, 131, 8'h66);
        push_beat(4095, 150, 140, 150, 130, 8'h77);

        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            if (ph == 3) begin
                send_idle_pct = 76;
                recv_idle_pct = 19;
            end
            else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            offs = '0;
            for (k = 0; k < SENSOR_COUNT; k++)
                offs[k*SAMPLE_W +: SAMPLE_W] = $urandom_range(400);
            case (ph)
                0: apply_setting(2900, 160, DEFAULT_OFFSETS, 1638, 9830, 300, 2984, 18691);
                1: apply_setting(12'hFFF, 12'hFFF, {CFG_DATA_W{1'b1}}, 16'hFFFF, 16'hFFFF,
                                 11'h7FF, 13'h1FFF, 16'hFFFF);
                2: apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
                4, 7: apply_setting($urandom_range(4095), $urandom_range(300), offs,
                                    $urandom_range(8000), $urandom_range(20000),
                                    $urandom_range(600), $urandom_range(4000, 1000),
                                    $urandom_range(40000, 5000));
                5: apply_setting(0, 0, {CFG_DATA_W{1'b1}}, 16'hFFFF, 0, 11'h7FF,
                                 13'h1FFF, 16'h1000);
                // Full-width random data also checks that upper bits are dropped.
                default: apply_setting({$urandom, $urandom}, {$urandom, $urandom},
                                       {$urandom, $urandom}, {$urandom, $urandom},
                                       {$urandom, $urandom}, {$urandom, $urandom},
                                       {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            queue_random_beats(PHASE_BEATS);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_steering.size() != 0)
            report_fault($sformatf("%0d results never arrived", expected_steering.size()));
        $display("tb_top: %0d sensor beats and %0d result beats over %0d register settings",
                 beats_accepted, results_seen, settings_applied);
        $display("tb_top: %0d with an invalid sum, %0d saturated positions, %0d mismatches",
                 invalid_seen, saturated_seen, mismatches);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
